// ===== rtl/per_pkg.sv =====
package per_pkg;

  // Coordinate and trig formats
  localparam int COORD_W    = 24;
  localparam int COORD_FRAC = 8;
  localparam int TRIG_FRAC  = 15;
  localparam int TRIG_W     = TRIG_FRAC + 2;       // signed, holds +/- 1.0 exactly
  localparam int ROM_W      = TRIG_FRAC + 1;       // unsigned magnitude, holds 1.0
  localparam int ANG_W      = 9;
  localparam int QTR_N      = 91;                  // 0..90 degrees
  localparam int QTR_IDX_W  = $clog2(QTR_N);

  // Working widths: three rotations grow a component by at most 2^1.5
  localparam int CALC_W     = COORD_W + 4;
  localparam int PROD_W     = CALC_W + TRIG_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int SAT_W      = CALC_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Z = CFG_IDX_W'(5);

  // Angle landmarks
  localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90);
  localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180);
  localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270);
  localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360);

  // ROM generation constants (Q30 Taylor series)
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] HalfTurn  = 64'd180;

  // Saturation bounds
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(2 ** (COORD_W - 1));

  typedef logic [QTR_N-1:0][ROM_W-1:0] sin_rom_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_z;
    logic signed [TRIG_W-1:0] sin_z;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_x;
  } trig_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pivot_t;

  // Quarter-wave sine table, evaluated once at elaboration
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t    rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    logic [63:0] accu;
    rom = '0;
    for (int d = 0; d < QTR_N; d++) begin
      x    = (64'(d) * PI_Q30 + HalfTurn / 2) / HalfTurn;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      // Terms x^3 .. x^15; each step divides by (2k)(2k+1), signs alternate
      term = ((term * x2) >> 30) / 64'd6;   acc = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;  acc = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;  acc = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;  acc = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd110; acc = acc - longint'(term);
      term = ((term * x2) >> 30) / 64'd156; acc = acc + longint'(term);
      term = ((term * x2) >> 30) / 64'd210; acc = acc - longint'(term);
      if (acc < 0) acc = 0;
      accu   = 64'(acc) + (64'd1 << (29 - TRIG_FRAC));
      rom[d] = ROM_W'(accu >> (30 - TRIG_FRAC));
    end
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

  function automatic logic signed [TRIG_W-1:0] sin_lookup(logic [ANG_W-1:0] d);
    logic [ANG_W-1:0]         r;
    logic                     neg;
    logic signed [TRIG_W-1:0] mag;
    if (d <= DEG_90) begin
      r = d; neg = 1'b0;
    end else if (d <= DEG_180) begin
      r = DEG_180 - d; neg = 1'b0;
    end else if (d <= DEG_270) begin
      r = d - DEG_180; neg = 1'b1;
    end else begin
      r = DEG_360 - d; neg = 1'b1;
    end
    mag = {1'b0, SIN_ROM[r[QTR_IDX_W-1:0]]};
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [TRIG_W-1:0] cos_lookup(logic [ANG_W-1:0] d);
    logic [ANG_W:0] e;
    e = {1'b0, d} + {1'b0, DEG_90};
    if (e >= {1'b0, DEG_360}) e = e - {1'b0, DEG_360};
    return sin_lookup(e[ANG_W-1:0]);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) return SAT_HI[COORD_W-1:0];
    if (v < SAT_LO) return SAT_LO[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/per_cfg.sv =====
module per_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [per_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [per_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output per_pkg::trig_t                 trig_o,
  output per_pkg::pivot_t                pivot_o
);
  import per_pkg::*;

  logic [ANG_W-1:0] ang_wr;
  logic [ANG_W-1:0] rot_z_q, rot_y_q, rot_x_q;
  pivot_t           pivot_q;
  trig_t            trig_d, trig_q;

  // Reduce the angle to 0..359 on write
  always_comb begin
    ang_wr = cfg_data_i[ANG_W-1:0];
    if (ang_wr >= DEG_360) ang_wr = ang_wr - DEG_360;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_z_q <= '0;
      rot_y_q <= '0;
      rot_x_q <= '0;
      pivot_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROT_Z:   rot_z_q   <= ang_wr;
        REG_ROT_Y:   rot_y_q   <= ang_wr;
        REG_ROT_X:   rot_x_q   <= ang_wr;
        REG_PIVOT_X: pivot_q.x <= cfg_data_i[COORD_W-1:0];
        REG_PIVOT_Y: pivot_q.y <= cfg_data_i[COORD_W-1:0];
        REG_PIVOT_Z: pivot_q.z <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Table lookups, registered behind the angle registers
  always_comb begin
    trig_d.cos_z = cos_lookup(rot_z_q);
    trig_d.sin_z = sin_lookup(rot_z_q);
    trig_d.cos_y = cos_lookup(rot_y_q);
    trig_d.sin_y = sin_lookup(rot_y_q);
    trig_d.cos_x = cos_lookup(rot_x_q);
    trig_d.sin_x = sin_lookup(rot_x_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= '{cos_z: TRIG_W'(2 ** TRIG_FRAC), sin_z: '0,
                  cos_y: TRIG_W'(2 ** TRIG_FRAC), sin_y: '0,
                  cos_x: TRIG_W'(2 ** TRIG_FRAC), sin_x: '0};
    end else begin
      trig_q <= trig_d;
    end
  end

  assign trig_o  = trig_q;
  assign pivot_o = pivot_q;

endmodule

// ===== rtl/per_rot.sv =====
module per_rot (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [per_pkg::TRIG_W-1:0]  cos_i,
  input  logic signed [per_pkg::TRIG_W-1:0]  sin_i,
  input  logic signed [per_pkg::CALC_W-1:0]  a_i,
  input  logic signed [per_pkg::CALC_W-1:0]  b_i,
  input  logic signed [per_pkg::CALC_W-1:0]  side_i,
  output logic                               valid_o,
  output logic signed [per_pkg::CALC_W-1:0]  u_o,
  output logic signed [per_pkg::CALC_W-1:0]  v_o,
  output logic signed [per_pkg::CALC_W-1:0]  side_o
);
  import per_pkg::*;

  // u = cos*a - sin*b, v = sin*a + cos*b, each rounded half up once
  logic                     p_valid_q;
  logic signed [PROD_W-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [CALC_W-1:0] p_side_q;
  logic signed [SUM_W-1:0]  su, sv, ru, rv;
  logic signed [CALC_W-1:0] u_d, v_d;
  logic                     valid_q;
  logic signed [CALC_W-1:0] u_q, v_q, side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      p_valid_q <= valid_i;
      valid_q   <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q     <= PROD_W'(cos_i) * PROD_W'(a_i);
    sb_q     <= PROD_W'(sin_i) * PROD_W'(b_i);
    sa_q     <= PROD_W'(sin_i) * PROD_W'(a_i);
    cb_q     <= PROD_W'(cos_i) * PROD_W'(b_i);
    p_side_q <= side_i;
  end

  always_comb begin
    su  = SUM_W'(ca_q) - SUM_W'(sb_q);
    sv  = SUM_W'(sa_q) + SUM_W'(cb_q);
    ru  = (su + SUM_W'(2 ** (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    rv  = (sv + SUM_W'(2 ** (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    u_d = ru[CALC_W-1:0];
    v_d = rv[CALC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    v_q    <= v_d;
    side_q <= p_side_q;
  end

  assign valid_o = valid_q;
  assign u_o     = u_q;
  assign v_o     = v_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/pivot_euler_rotate_project_top.sv =====
// Pipeline: the pivot subtract, two stages per axis rotation, then the pivot add and clamp.
// Throughput: one point per cycle; busy_o stays low, the receiver cannot stall, and each word
//   sits on the ports for exactly one cycle, marked by valid_o.
// Reset: rst_ni is asynchronous, active low; it clears all valid bits, sets the angles
//   and pivot to zero and loads the unit-rotation sine/cosine values.
module pivot_euler_rotate_project_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Point channel
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [per_pkg::COORD_W-1:0]    point_x_i,
  input  logic signed [per_pkg::COORD_W-1:0]    point_y_i,
  input  logic signed [per_pkg::COORD_W-1:0]    point_z_i,
  // Result channel
  output logic                                  valid_o,
  output logic signed [per_pkg::COORD_W-1:0]    screen_x_o,
  output logic signed [per_pkg::COORD_W-1:0]    screen_y_o,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [per_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [per_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import per_pkg::*;

  trig_t  trig;
  pivot_t pivot;

  // Angles, pivot and the registered table lookups live here
  per_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .trig_o     (trig),
    .pivot_o    (pivot)
  );

  // Every cycle takes a word
  assign busy_o = 1'b0;

  // Stage 1: move the point to pivot-relative coordinates
  logic                     in_fire;
  logic                     s1_valid_q;
  logic signed [CALC_W-1:0] s1_x_q, s1_y_q, s1_z_q;

  assign in_fire = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q <= CALC_W'(point_x_i) - CALC_W'(pivot.x);
    s1_y_q <= CALC_W'(point_y_i) - CALC_W'(pivot.y);
    s1_z_q <= CALC_W'(point_z_i) - CALC_W'(pivot.z);
  end

  // Stages 2-3: rotate about Z on (x, y); carry z alongside
  logic                     z_valid;
  logic signed [CALC_W-1:0] z_x, z_y, z_z;

  per_rot u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .cos_i   (trig.cos_z),
    .sin_i   (trig.sin_z),
    .a_i     (s1_x_q),
    .b_i     (s1_y_q),
    .side_i  (s1_z_q),
    .valid_o (z_valid),
    .u_o     (z_x),
    .v_o     (z_y),
    .side_o  (z_z)
  );

  // Stages 4-5: rotate about Y on (z, x): u gives the new z, v the new x
  logic                     y_valid;
  logic signed [CALC_W-1:0] y_x, y_y, y_z;

  per_rot u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (z_valid),
    .cos_i   (trig.cos_y),
    .sin_i   (trig.sin_y),
    .a_i     (z_z),
    .b_i     (z_x),
    .side_i  (z_y),
    .valid_o (y_valid),
    .u_o     (y_z),
    .v_o     (y_x),
    .side_o  (y_y)
  );

  // Stages 6-7: rotate about X on (y, z); only the new y is kept, z drops out
  logic                     x_valid;
  logic signed [CALC_W-1:0] x_x, x_y;

  per_rot u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (y_valid),
    .cos_i   (trig.cos_x),
    .sin_i   (trig.sin_x),
    .a_i     (y_y),
    .b_i     (y_z),
    .side_i  (y_x),
    .valid_o (x_valid),
    .u_o     (x_y),
    .v_o     (),
    .side_o  (x_x)
  );

  // Stage 8: add the pivot back and clamp to the coordinate range
  logic                      out_valid_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic signed [SAT_W-1:0]   sum_x, sum_y;

  assign sum_x = SAT_W'(x_x) + SAT_W'(pivot.x);
  assign sum_y = SAT_W'(x_y) + SAT_W'(pivot.y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= x_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q <= sat_coord(sum_x);
    out_y_q <= sat_coord(sum_y);
  end

  assign valid_o    = out_valid_q;
  assign screen_x_o = out_x_q;
  assign screen_y_o = out_y_q;

  // Every accepted point comes out as a screen word
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##8 valid_o)
    else $error("accepted point did not produce a word after 8 cycles");

  // No word appears without a matching accepted point
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_fire, 8))
    else $error("word produced with no matching accepted point");

  // Valid bits advance in lockstep through the rotation stages
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ##2 z_valid ##2 y_valid ##2 x_valid)
    else $error("valid bit lost inside the rotation pipeline");

endmodule

// ===== dv/pivot_euler_rotate_project_top_tb.sv =====
module pivot_euler_rotate_project_top_tb;

  // Coordinate and configuration word types at the block's widths
  typedef logic signed [per_pkg::COORD_W-1:0] coord_t;
  typedef logic [per_pkg::CFG_DATA_W-1:0]     cfg_word_t;
  typedef logic [per_pkg::CFG_IDX_W-1:0]      cfg_idx_t;

  // One screen word as the block should present it
  typedef struct {
    coord_t sx;
    coord_t sy;
  } screen_word_t;

  localparam coord_t COORD_MAX = {1'b0, {(per_pkg::COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(per_pkg::COORD_W-1){1'b0}}};

  // Register indexes past the end of the map; writes there must be dropped
  localparam cfg_idx_t REG_SPARE_LO = cfg_idx_t'(6);
  localparam cfg_idx_t REG_SPARE_HI = cfg_idx_t'(7);

  // Angle landmarks in whole degrees
  localparam int unsigned QUARTER_TURN = 90;
  localparam int unsigned HALF_TURN    = 180;
  localparam int unsigned THREE_QUARTER = 270;
  localparam int unsigned FULL_TURN    = 360;
  localparam int unsigned LAST_DEGREE  = 359;
  localparam int unsigned ANGLE_FIELD_MAX = 511;

  // Sine table generation in Q30
  localparam longint unsigned PI_FIXED30 = 64'd3373259426;
  localparam int              Q30_SHIFT  = 30;
  localparam int              TAYLOR_TERMS = 7;
  localparam int              TF = per_pkg::TRIG_FRAC;

  // Pipeline depth from point to screen word, plus slack for the drain at the end
  localparam int PIPE_DEPTH  = 8;
  localparam int TAIL_CYCLES = PIPE_DEPTH + 20;
  localparam int RANDOM_PHASES = 7;
  localparam int POINTS_PER_PHASE = 64;
  // Watchdog limit, with a wide margin over the longest run
  localparam int CYCLE_LIMIT = 250000;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      start_i    = 1'b0;
  coord_t    point_x_i  = '0;
  coord_t    point_y_i  = '0;
  coord_t    point_z_i  = '0;
  logic      cfg_we_i   = 1'b0;
  cfg_idx_t  cfg_idx_i  = '0;
  cfg_word_t cfg_data_i = '0;
  logic      busy_o;
  logic      valid_o;
  coord_t    screen_x_o;
  coord_t    screen_y_o;

  // Shadow copy of the block's configuration, as held after reduction
  int unsigned ang_z_m = 0;
  int unsigned ang_y_m = 0;
  int unsigned ang_x_m = 0;
  longint      pivot_x_m = 0;
  longint      pivot_y_m = 0;
  longint      pivot_z_m = 0;

  screen_word_t screen_q[$];
  screen_word_t oldest_word;

  int  n_errors      = 0;
  int  n_points      = 0;
  int  n_words       = 0;
  int  n_cfg_writes  = 0;
  int  n_drains      = 0;
  int  cycle_count   = 0;
  bit  burst_mode    = 1'b0;

  pivot_euler_rotate_project_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .valid_o    (valid_o),
    .screen_x_o (screen_x_o),
    .screen_y_o (screen_y_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: sine/cosine from a Q30 Taylor series, three single-axis
  // rotations each rounded once to the coordinate grid, then saturation.
  // ---------------------------------------------------------------------------

  // Sine of 0..90 degrees in TF fraction bits, rounded half up from Q30
  function automatic longint quarter_sine(int unsigned deg);
    longint unsigned arg;
    longint unsigned arg_sq;
    longint unsigned term;
    longint          acc;
    arg    = (64'(deg) * PI_FIXED30 + 64'(HALF_TURN / 2)) / 64'(HALF_TURN);
    arg_sq = (arg * arg) >> Q30_SHIFT;
    term   = arg;
    acc    = longint'(arg);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * arg_sq) >> Q30_SHIFT) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    return longint'((64'(acc) + (64'd1 << (Q30_SHIFT - 1 - TF))) >> (Q30_SHIFT - TF));
  endfunction

  // Fold any held angle onto the quarter wave
  function automatic longint sine_of(int unsigned deg);
    if (deg <= QUARTER_TURN) return quarter_sine(deg);
    if (deg <= HALF_TURN) return quarter_sine(HALF_TURN - deg);
    if (deg <= THREE_QUARTER) return -quarter_sine(deg - HALF_TURN);
    return -quarter_sine(FULL_TURN - deg);
  endfunction

  function automatic longint cosine_of(int unsigned deg);
    return sine_of((deg + QUARTER_TURN) % FULL_TURN);
  endfunction

  // Drop TF fraction bits, ties toward plus infinity
  function automatic longint round_grid(longint v);
    return (v + (longint'(1) <<< (TF - 1))) >>> TF;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic screen_word_t project_point(coord_t px, coord_t py, coord_t pz);
    longint       cx;
    longint       cy;
    longint       cz;
    longint       c;
    longint       s;
    longint       nx;
    longint       ny;
    longint       nz;
    screen_word_t w;
    // Move the pivot to the origin
    cx = longint'(px) - pivot_x_m;
    cy = longint'(py) - pivot_y_m;
    cz = longint'(pz) - pivot_z_m;
    // Rotate about Z
    c  = cosine_of(ang_z_m);
    s  = sine_of(ang_z_m);
    nx = round_grid(c * cx - s * cy);
    ny = round_grid(s * cx + c * cy);
    cx = nx;
    cy = ny;
    // Rotate about Y
    c  = cosine_of(ang_y_m);
    s  = sine_of(ang_y_m);
    nx = round_grid(c * cx + s * cz);
    nz = round_grid(c * cz - s * cx);
    cx = nx;
    cz = nz;
    // Rotate about X; only Y survives the projection
    c  = cosine_of(ang_x_m);
    s  = sine_of(ang_x_m);
    cy = round_grid(c * cy - s * cz);
    // Move back and clip to the screen range
    w.sx = clamp_coord(cx + pivot_x_m);
    w.sy = clamp_coord(cy + pivot_y_m);
    return w;
  endfunction

  // Mirror one register write; angles wrap once by a full turn, spare indexes drop
  function automatic void shadow_cfg(cfg_idx_t idx, cfg_word_t data);
    int unsigned a;
    a = int'(data[per_pkg::ANG_W-1:0]);
    if (a >= FULL_TURN) a -= FULL_TURN;
    case (idx)
      per_pkg::REG_ROT_Z:   ang_z_m = a;
      per_pkg::REG_ROT_Y:   ang_y_m = a;
      per_pkg::REG_ROT_X:   ang_x_m = a;
      per_pkg::REG_PIVOT_X: pivot_x_m = longint'($signed(data));
      per_pkg::REG_PIVOT_Y: pivot_y_m = longint'($signed(data));
      per_pkg::REG_PIVOT_Z: pivot_z_m = longint'($signed(data));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a rare long one; none in burst mode
  function automatic int unsigned pick_gap();
    if (burst_mode) return 0;
    case ($urandom_range(0, 19))
      0:             return $urandom_range(8, 40);
      1, 2, 3, 4, 5: return $urandom_range(1, 3);
      default:       return 0;
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      1:       return coord_t'(int'($urandom_range(0, 2)) - 1);
      2, 3:    return coord_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Angle in the low bits; sometimes junk above them, sometimes a value past 359
  function automatic cfg_word_t rand_angle_word();
    cfg_word_t   w;
    int unsigned a;
    case ($urandom_range(0, 9))
      0:       a = 0;
      1:       a = QUARTER_TURN;
      2:       a = LAST_DEGREE;
      3:       a = $urandom_range(FULL_TURN, ANGLE_FIELD_MAX);
      default: a = $urandom_range(0, LAST_DEGREE);
    endcase
    w = $urandom_range(0, 3) == 0 ? cfg_word_t'($urandom) : '0;
    w[per_pkg::ANG_W-1:0] = a[per_pkg::ANG_W-1:0];
    return w;
  endfunction

  function automatic cfg_word_t rand_pivot_word();
    case ($urandom_range(0, 7))
      0:       return cfg_word_t'(COORD_MAX);
      1:       return cfg_word_t'(COORD_MIN);
      2:       return '0;
      3, 4:    return cfg_word_t'(int'($urandom_range(0, 65535)) - 32768);
      default: return cfg_word_t'($urandom);
    endcase
  endfunction

  // Present one point, hold it until taken, then maybe idle.
  // Leaves start_i high when no gap follows so the next word goes back to back.
  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
    int unsigned gap;
    start_i   <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    screen_q.push_back(project_point(px, py, pz));
    n_points++;
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding screen word
  task automatic drain_screen();
    start_i <= 1'b0;
    do @(posedge clk_i); while (screen_q.size() != 0);
    n_drains++;
  endtask

  // One register write; the enable is then driven low again before the task returns
  task automatic cfg_write(input cfg_idx_t idx, input cfg_word_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    shadow_cfg(idx, data);
    n_cfg_writes++;
    cfg_we_i   <= 1'b0;
    cfg_data_i <= cfg_word_t'($urandom);
    @(posedge clk_i);
  endtask

  task automatic cfg_all(input cfg_word_t az, input cfg_word_t ay, input cfg_word_t ax,
                         input cfg_word_t pvx, input cfg_word_t pvy, input cfg_word_t pvz);
    cfg_write(per_pkg::REG_ROT_Z, az);
    cfg_write(per_pkg::REG_ROT_Y, ay);
    cfg_write(per_pkg::REG_ROT_X, ax);
    cfg_write(per_pkg::REG_PIVOT_X, pvx);
    cfg_write(per_pkg::REG_PIVOT_Y, pvy);
    cfg_write(per_pkg::REG_PIVOT_Z, pvz);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config is the identity about the origin: points pass straight through
  task automatic test_identity_extremes();
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point('0, '0, '0);
    send_point(coord_t'(-1), coord_t'(1), coord_t'(-1));
    send_point(COORD_MAX, COORD_MIN, '0);
    drain_screen();
  endtask

  // Exact quarter turns, the last degree and a diagonal that saturates
  task automatic test_quarter_turns();
    cfg_all(cfg_word_t'(QUARTER_TURN), cfg_word_t'(HALF_TURN), cfg_word_t'(THREE_QUARTER),
            '0, '0, '0);
    send_point(COORD_MAX, COORD_MIN, coord_t'(12345));
    send_point(COORD_MIN, COORD_MAX, COORD_MIN);
    send_point(coord_t'(256), coord_t'(-256), coord_t'(513));
    drain_screen();
    cfg_all(cfg_word_t'(45), cfg_word_t'(LAST_DEGREE), cfg_word_t'(1), '0, '0, '0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MAX);
    drain_screen();
  endtask

  // Angles written at or past a full turn wrap; writes past the map are dropped
  task automatic test_angle_wrap();
    cfg_all(cfg_word_t'(FULL_TURN), cfg_word_t'(ANGLE_FIELD_MAX), cfg_word_t'(450),
            cfg_word_t'(1000), cfg_word_t'(-2000), cfg_word_t'(77));
    cfg_write(REG_SPARE_LO, cfg_word_t'($urandom));
    cfg_write(REG_SPARE_HI, '1);
    send_point(coord_t'(100000), coord_t'(-50000), coord_t'(25000));
    send_point(COORD_MAX, '0, COORD_MIN);
    send_point(coord_t'(-1), coord_t'(-1), coord_t'(-1));
    drain_screen();
  endtask

  // Pivot at the corners: offsets span the full doubled range and clip hard
  task automatic test_pivot_extremes();
    cfg_all(cfg_word_t'(HALF_TURN), '0, cfg_word_t'(HALF_TURN),
            cfg_word_t'(COORD_MIN), cfg_word_t'(COORD_MAX), cfg_word_t'(COORD_MAX));
    send_point(COORD_MAX, COORD_MIN, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX, COORD_MAX);
    drain_screen();
    cfg_all(cfg_word_t'(LAST_DEGREE), cfg_word_t'(QUARTER_TURN), cfg_word_t'(LAST_DEGREE),
            cfg_word_t'(COORD_MAX), cfg_word_t'(COORD_MIN), cfg_word_t'(COORD_MIN));
    send_point(COORD_MIN, COORD_MAX, COORD_MAX);
    send_point(COORD_MAX, COORD_MIN, '0);
    drain_screen();
  endtask

  // Random configs, random points; every other phase runs without idling and
  // each phase pauses once mid-stream until the pipeline is empty
  task automatic test_random_sweep();
    int unsigned pause_at;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      cfg_all(rand_angle_word(), rand_angle_word(), rand_angle_word(),
              rand_pivot_word(), rand_pivot_word(), rand_pivot_word());
      burst_mode = (phase % 2) == 0;
      pause_at   = $urandom_range(1, POINTS_PER_PHASE - 2);
      for (int i = 0; i < POINTS_PER_PHASE; i++) begin
        if (i == pause_at) drain_screen();
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
      drain_screen();
    end
    burst_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Checking: every screen word is compared with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (screen_q.size() == 0) begin
        $error("screen word with nothing pending: x=%0d y=%0d", screen_x_o, screen_y_o);
        n_errors++;
      end else begin
        oldest_word = screen_q.pop_front();
        n_words++;
        if (screen_x_o !== oldest_word.sx) begin
          $error("screen_x: expected %0d, got %0d", oldest_word.sx, screen_x_o);
          n_errors++;
        end
        if (screen_y_o !== oldest_word.sy) begin
          $error("screen_y: expected %0d, got %0d", oldest_word.sy, screen_y_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count, screen_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Hold reset low, then release it on an edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_extremes();
    test_quarter_turns();
    test_angle_wrap();
    test_pivot_extremes();
    test_random_sweep();

    // Wait out the pipeline, then watch a little longer for stray words
    drain_screen();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (screen_q.size() != 0) begin
      $error("%0d screen words never arrived", screen_q.size());
      n_errors += screen_q.size();
    end

    $display("sent %0d points, checked %0d screen words, %0d register writes, %0d drains",
             n_points, n_words, n_cfg_writes, n_drains);
    $display("covered quarter turns, angle wrap, spare indexes, pivot corners, %0d errors",
             n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
